// ===== rtl/tdp_pkg.sv =====
// Shared types for the trial-division prime test.
`default_nettype none

package tdp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tdp_value_if.sv =====
// Input channel: value to test, valid/ready handshake.
`default_nettype none

interface tdp_value_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdp_result_if.sv =====
// Output channel: primality flag, valid/ready handshake.
`default_nettype none

interface tdp_result_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdp_rem_unit.sv =====
// Bit-serial restoring divider: quotient and remainder, one bit per cycle.
`default_nettype none

module tdp_rem_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output logic      [VALUE_WIDTH-1:0] quot_o,
  output logic      [VALUE_WIDTH-1:0] rem_o,
  output tdp_pkg::div_stat_t          stat_o
);
  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] dsr_q, dsr_d;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   rem_sub;
  logic                   fits;

  always_comb begin
    rem_sh  = {rem_q, quot_q[VALUE_WIDTH-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    fits    = rem_sh >= {1'b0, dsr_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i && (cnt_q == '0)) begin
      cnt_d  = CntW'(VALUE_WIDTH);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
      rem_d  = fits ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
      quot_d = {quot_q[VALUE_WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign quot_o      = quot_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/trial_division_prime_test.sv =====
// Top level: trial-division primality test over a shared serial divider.
//
//  port      dir  beat        fields
//  value_i   in   one value   value (VALUE_WIDTH, signed)
//  result_o  out  one result  is_prime (1)
//
// Negative, zero, one and even values finish in the cycle after the beat.
// Odd values try divisors 3, 5, 7, ... while d <= n / d; each trial runs
// the serial divider once, and a zero remainder ends the test as composite.
// value_i.ready is high only when idle; the result holds until taken.
// Reset clears the sequencer and divider counter.
`default_nettype none

module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tdp_value_if.sink      value_i,
  tdp_result_if.source   result_o
);
  tdp_pkg::state_e        state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic                   res_q, res_d;
  logic                   start;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] in_bits;
  logic [VALUE_WIDTH-1:0] quot;
  logic [VALUE_WIDTH-1:0] rem;
  tdp_pkg::div_stat_t     div_stat;

  tdp_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .dividend_i(dividend),
    .divisor_i (d_d),
    .quot_o    (quot),
    .rem_o     (rem),
    .stat_o    (div_stat)
  );

  assign in_bits = value_i.value;

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    d_d      = d_q;
    res_d    = res_q;
    start    = 1'b0;
    dividend = n_q;
    unique case (state_q)
      tdp_pkg::ST_IDLE: begin
        if (value_i.valid) begin
          n_d = in_bits;
          if (in_bits[VALUE_WIDTH-1] || (in_bits[VALUE_WIDTH-1:1] == '0)) begin
            res_d   = 1'b0;
            state_d = tdp_pkg::ST_OUT;
          end else if (!in_bits[0]) begin
            res_d   = (in_bits == VALUE_WIDTH'(2));
            state_d = tdp_pkg::ST_OUT;
          end else begin
            d_d      = VALUE_WIDTH'(3);
            dividend = in_bits;
            start    = 1'b1;
            state_d  = tdp_pkg::ST_DIV;
          end
        end
      end
      tdp_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (d_q > quot) begin
            res_d   = 1'b1;
            state_d = tdp_pkg::ST_OUT;
          end else if (rem == '0) begin
            res_d   = 1'b0;
            state_d = tdp_pkg::ST_OUT;
          end else begin
            d_d   = d_q + VALUE_WIDTH'(2);
            start = 1'b1;
          end
        end
      end
      tdp_pkg::ST_OUT: begin
        if (result_o.ready) begin
          state_d = tdp_pkg::ST_IDLE;
        end
      end
      default: state_d = tdp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    res_q <= res_d;
  end

  assign value_i.ready     = (state_q == tdp_pkg::ST_IDLE);
  assign result_o.valid    = (state_q == tdp_pkg::ST_OUT);
  assign result_o.is_prime = res_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !value_i.ready)
    else $error("input taken while a result is pending");

  a_div_in_trial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == tdp_pkg::ST_DIV))
    else $error("divider busy outside trial state");

  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdp_pkg::ST_DIV) |-> d_q[0])
    else $error("even trial divisor");

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> $past(div_stat.busy))
    else $error("divider done without a running division");

endmodule

`default_nettype wire
